FILE: design/pmts_pkg.sv
// Shared widths, defaults and control types for the plus/minus target sum search.
`timescale 1ns / 1ps

package pmts_pkg;

    localparam int DEF_MAX_TERMS  = 15;
    localparam int DEF_VALUE_BITS = 16;

    localparam int VALUE_W  = 16;
    localparam int TARGET_W = 21;
    localparam int MASK_W   = 14;
    localparam int COUNT_W  = 4;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // Commands from the sequencer to the shared add/subtract unit
    typedef struct packed {
        logic load;
        logic step;
        logic minus;
    } acc_ctrl_t;

endpackage

FILE: design/pmts_store.sv
// Register file holding the numbers of the current sequence.
`timescale 1ns / 1ps

module pmts_store
    import pmts_pkg::*;
#(
    parameter int MAX_TERMS  = DEF_MAX_TERMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem_reg [MAX_TERMS];
    logic [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        // Pass a same-cycle write straight through to the read port
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pmts_accum.sv
// Shared add/subtract unit with the running signed sum and the target compare.
`timescale 1ns / 1ps

module pmts_accum
    import pmts_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int SUM_W     = (VALUE_BITS + 6 > TARGET_W) ? VALUE_BITS + 6 : TARGET_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  acc_ctrl_t                  ctrl,
    input  logic [VALUE_BITS-1:0]      operand,
    input  logic signed [TARGET_W-1:0] goal,
    output logic                       equal
);

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic signed [SUM_W-1:0] opnd_ext;
    logic signed [SUM_W-1:0] goal_ext;

    assign opnd_ext = $signed(SUM_W'(operand));
    assign goal_ext = SUM_W'(goal);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = opnd_ext;
        end
        else if (ctrl.step)
        begin
            acc_next = ctrl.minus ? (acc_reg - opnd_ext) : (acc_reg + opnd_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign equal = (acc_reg == goal_ext);

endmodule

FILE: design/plus_minus_target_sum_search.sv
// Numbers stream in one item per cycle while s_axis_tready is high; the item with tlast
// closes the sequence of n numbers and carries the target. The block then goes through the
// 2^(n-1) plus/minus patterns over numbers 2..n until one matches, plus tried before minus
// with number 2 the most significant choice, and delivers one result item: found, the plus
// mask of the first matching pattern, and n. One adder/subtractor is shared: each pattern
// loads number 1, adds or subtracts numbers 2..n one at a time, then compares the sum with
// the target, and s_axis_tready stays low until the result has gone into the output
// register. Numbers beyond MAX_TERMS in one sequence are dropped. The result sits in an
// output register, so loading of the next sequence starts while it waits to be taken.
`timescale 1ns / 1ps

module plus_minus_target_sum_search
    import pmts_pkg::*;
#(
    parameter int MAX_TERMS  = DEF_MAX_TERMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // value [15:0], target [36:16], zero pad
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // plus_mask [13:0], term_count [17:14], zero pad
    output logic                m_axis_tuser    // found
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int PAT_W = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [PAT_W-1:0]           pat_reg, pat_next;
    logic [PAT_W-1:0]           pm_reg, pm_next;
    logic signed [TARGET_W-1:0] goal_reg, goal_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_found_reg, out_found_next;
    logic [MASK_W-1:0]          out_mask_reg, out_mask_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;

    logic                       in_fire;
    logic                       room;
    logic                       wr_en;
    logic [VALUE_BITS-1:0]      wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic [VALUE_BITS-1:0]      rd_data;
    logic                       equal;
    acc_ctrl_t                  ctrl;
    logic [PAT_W:0]             pat_span;
    logic [PAT_W-1:0]           pat_last;
    logic [CNT_W-1:0]           sign_pos;
    logic                       minus;
    logic                       out_free;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign room          = (count_reg < CNT_W'(MAX_TERMS));
    assign wr_en         = in_fire & room;
    assign wr_data       = VALUE_BITS'({{32{1'b0}}, s_axis_tdata[VALUE_W-1:0]});
    // Drive the address from the next-state values, since the store read is registered
    assign rd_addr       = (state_next == S_SUM) ? k_next[IDX_W-1:0] : '0;

    // Last pattern index is 2^(n-1) - 1
    assign pat_span = ((PAT_W + 1)'(1) << (n_reg - CNT_W'(1))) - (PAT_W + 1)'(1);
    assign pat_last = pat_span[PAT_W-1:0];

    // Number k+1 (store index k) takes its sign from pattern bit n-1-k
    assign sign_pos = n_reg - k_reg - CNT_W'(1);
    assign minus    = pat_reg[sign_pos[IDX_W-1:0]];
    assign out_free = !out_valid_reg || m_axis_tready;

    pmts_store #(
        .MAX_TERMS  (MAX_TERMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pmts_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .operand (rd_data),
        .goal    (goal_reg),
        .equal   (equal)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        pat_next       = pat_reg;
        pm_next        = pm_reg;
        goal_next      = goal_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_mask_next  = out_mask_reg;
        out_count_next = out_count_reg;
        ctrl           = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        n_next     = room ? count_reg + CNT_W'(1) : count_reg;
                        goal_next  = s_axis_tdata[VALUE_W +: TARGET_W];
                        pat_next   = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                ctrl.load  = 1'b1;
                k_next     = CNT_W'(1);
                pm_next    = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (k_reg < n_reg)
                begin
                    ctrl.step  = 1'b1;
                    ctrl.minus = minus;
                    if (!minus)
                    begin
                        pm_next = pm_reg | (PAT_W'(1) << (k_reg - CNT_W'(1)));
                    end
                    k_next = k_reg + CNT_W'(1);
                end
                else if (equal || (pat_reg == pat_last))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pat_next   = pat_reg + PAT_W'(1);
                    state_next = S_INIT;
                end
            end
            S_DONE:
            begin
                // Hold the finished result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = equal;
                    out_mask_next  = equal ? MASK_W'({{MASK_W{1'b0}}, pm_reg}) : '0;
                    out_count_next = COUNT_W'({{COUNT_W{1'b0}}, n_reg});
                    count_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        pat_reg       <= pat_next;
        pm_reg        <= pm_next;
        goal_reg      <= goal_next;
        out_found_reg <= out_found_next;
        out_mask_reg  <= out_mask_next;
        out_count_reg <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(M_DATA_W - MASK_W - COUNT_W){1'b0}}, out_count_reg, out_mask_reg};

endmodule

FILE: sim/plus_minus_target_sum_search_tb.sv
// Self-checking testbench for the plus/minus target sum search block.
`timescale 1ns / 1ps

module plus_minus_target_sum_search_tb;
    import pmts_pkg::*;

    localparam int N_TERMS      = DEF_MAX_TERMS;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int TARGET_MAX   = 983025;

    typedef logic [VALUE_W-1:0] term_array_t [N_TERMS];

    typedef struct packed {
        logic               found;
        logic [MASK_W-1:0]  plus_mask;
        logic [COUNT_W-1:0] term_count;
    } search_result_t;

    typedef struct {
        logic [VALUE_W-1:0]         value;
        logic                       last;
        logic signed [TARGET_W-1:0] target;
        bit                         typed;
        search_result_t             want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;   // value [15:0], target [36:16], zero pad
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // plus_mask [13:0], term_count [17:14], zero pad
    logic                m_axis_tuser;   // found

    search_result_t pending_results[$];
    term_array_t    seq_values;
    int             seq_len;
    int             mismatches;
    int             burst_left;
    int             idle_cycles;

    // Typed rows carry results that follow directly from the numbers.
    stim_row_t directed_rows[25] = '{
        '{16'd0,     1'b1, 21'sd0,        1'b1, '{1'b1, 14'h0000, 4'd1}},
        '{16'hFFFF,  1'b1, 21'sd983025,   1'b1, '{1'b0, 14'h0000, 4'd1}},
        '{16'hFFFF,  1'b1, 21'sd65535,    1'b1, '{1'b1, 14'h0000, 4'd1}},
        '{16'd5,     1'b0, 21'sd0,        1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'd3,     1'b1, 21'sd2,        1'b1, '{1'b1, 14'h0000, 4'd2}},
        '{16'd1,     1'b0, 21'sd0,        1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'd2,     1'b0, 21'sd0,        1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'd3,     1'b1, 21'sd0,        1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, 21'sd0,        1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'd0,     1'b1, 21'sd65535,    1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        '{16'hFFFF,  1'b0, -21'sd983025,  1'b0, '{1'b0, 14'h0000, 4'd0}},
        // full sequence of maximum numbers below the lowest reachable sum: no match
        '{16'hFFFF,  1'b1, -21'sd983025,  1'b1, '{1'b0, 14'h0000, 4'd15}}
    };

    plus_minus_target_sum_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Signed sum of pattern idx; bit n-k of idx set means number k gets minus.
    function automatic int pattern_sum(input term_array_t vals, input int n, input int idx,
                                       output logic [MASK_W-1:0] pm);
        int acc;
        acc = int'(vals[0]);
        pm  = '0;
        for (int k = 2; k <= n; k++)
        begin
            if (((idx >> (n - k)) & 1) == 0)
            begin
                acc = acc + int'(vals[k-1]);
                pm[k-2] = 1'b1;
            end
            else
            begin
                acc = acc - int'(vals[k-1]);
            end
        end
        return acc;
    endfunction

    function automatic search_result_t find_sign_pattern(input term_array_t vals, input int n,
                                                         input logic signed [TARGET_W-1:0] goal);
        search_result_t res;
        logic [MASK_W-1:0] pm;
        int total;
        res.found      = 1'b0;
        res.plus_mask  = '0;
        res.term_count = COUNT_W'(n);
        total = 1 << (n - 1);
        for (int i = 0; i < total; i++)
        begin
            if (pattern_sum(vals, n, i, pm) == int'(goal))
            begin
                res.found     = 1'b1;
                res.plus_mask = pm;
                break;
            end
        end
        return res;
    endfunction

    // Store one number; on the closing item run the search and clear the sequence.
    function automatic bit record_term(input logic [VALUE_W-1:0] value, input logic last,
                                       input logic signed [TARGET_W-1:0] target,
                                       output search_result_t res);
        res = '0;
        if (seq_len < N_TERMS)
        begin
            seq_values[seq_len] = value;
            seq_len++;
        end
        if (!last)
            return 1'b0;
        res = find_sign_pattern(seq_values, seq_len, target);
        seq_len = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [TARGET_W-1:0] random_target();
        return TARGET_W'(int'($urandom_range(0, 2 * TARGET_MAX)) - TARGET_MAX);
    endfunction

    task automatic send_item(input logic [VALUE_W-1:0] value, input logic last,
                             input logic signed [TARGET_W-1:0] target);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - TARGET_W - VALUE_W){1'b0}}, target, value};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic issue_item(input logic [VALUE_W-1:0] value, input logic last,
                              input logic signed [TARGET_W-1:0] target,
                              input bit typed, input search_result_t want);
        search_result_t predicted;
        send_item(value, last, target);
        if (record_term(value, last, target, predicted))
            pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    // Drop valid and hold off until every outstanding result has been taken.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_sequence(output int sent);
        logic [VALUE_W-1:0] planned [N_TERMS + 3];
        term_array_t plan;
        logic [MASK_W-1:0] pm;
        logic signed [TARGET_W-1:0] goal;
        int len, n, span, idx, style, pick;
        pick  = $urandom_range(0, 99);
        len   = (pick < 80) ? $urandom_range(1, 6) :
                (pick < 92) ? $urandom_range(7, 10) : $urandom_range(11, N_TERMS + 3);
        style = $urandom_range(0, 3);
        plan  = '{default: '0};
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: planned[i] = VALUE_W'($urandom);
                1: planned[i] = VALUE_W'($urandom_range(0, 15));
                2: planned[i] = ($urandom_range(0, 2) == 0) ? VALUE_W'($urandom) :
                                ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: planned[i] = VALUE_W'($urandom_range(0, 255));
            endcase
            if (i < N_TERMS)
                plan[i] = planned[i];
        end
        n    = (len > N_TERMS) ? N_TERMS : len;
        span = 1 << (n - 1);
        // Long sequences aim at an early pattern to keep the search short.
        if (len > 10)
        begin
            idx  = $urandom_range(0, (span > 64) ? 63 : span - 1);
            goal = TARGET_W'(pattern_sum(plan, n, idx, pm));
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                idx  = $urandom_range(0, span - 1);
                goal = TARGET_W'(pattern_sum(plan, n, idx, pm));
            end
            else if (pick < 9)
                goal = random_target();
            else
                goal = TARGET_W'(int'($urandom_range(0, 16)) - 8);
        end
        for (int i = 0; i < len; i++)
        begin
            issue_item(planned[i], i == len - 1, (i == len - 1) ? goal : random_target(),
                       1'b0, '0);
        end
        sent = len;
    endtask

    initial
    begin
        int sent;
        int total_random;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        mismatches    = 0;
        seq_len       = 0;
        burst_left    = 0;
        seq_values    = '{default: '0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            issue_item(directed_rows[r].value, directed_rows[r].last, directed_rows[r].target,
                       directed_rows[r].typed, directed_rows[r].want);
        end
        wait_for_results();

        total_random = 0;
        while (total_random < RANDOM_ITEMS)
        begin
            send_random_sequence(sent);
            total_random += sent;
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: switch at random between stall modes, from always ready to never ready.
    initial
    begin
        int hold_left;
        int mode;
        m_axis_tready = 1'b0;
        hold_left = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0)
            begin
                hold_left = $urandom_range(8, 80);
                mode = $urandom_range(0, 3);
            end
            hold_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        search_result_t got;
        search_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found      = m_axis_tuser;
            got.plus_mask  = m_axis_tdata[MASK_W-1:0];
            got.term_count = m_axis_tdata[MASK_W +: COUNT_W];
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: found=%0d mask=%h count=%0d",
                             got.found, got.plus_mask, got.term_count);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.plus_mask !== want.plus_mask ||
                    got.term_count !== want.term_count)
                begin
                    // Fields in order found / mask / count
                    if (mismatches < MAX_REPORTS)
                        $display("result mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                 want.found, want.plus_mask, want.term_count,
                                 got.found, got.plus_mask, got.term_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no item moving on either side.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
